/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect clk, AKDS_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AKDS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AKDS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/akds_pkg.sv */
package akds_pkg;

    // Angle resolution of the sensor circle.
    localparam int ANGLE_BITS = 12;

    // Fixed field widths.
    localparam int ANG_IN_W   = 12;
    localparam int WIDE_W     = 16;
    localparam int ACT_W      = 24;
    localparam int TICK_W     = 12;
    localparam int DZ_W       = 11;
    localparam int DIV_W      = 12;
    localparam int MODE_W     = 4;
    localparam int TAP_W      = 2;
    localparam int SCR_W      = 13;
    localparam int LOCK_N     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Derived widths.
    localparam int D_W       = ANGLE_BITS + 1;
    localparam int MAG_W     = ANGLE_BITS;
    localparam int CMP_W     = ((D_W > TICK_W + 1) ? D_W : TICK_W + 1) + 1;
    localparam int QW        = (MAG_W > SCR_W) ? MAG_W : SCR_W;
    localparam int REM_W     = DIV_W + 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int SCROLL_MAX = 2048;

    // Item kinds.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOCK   = 1'b1;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_NONE       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SCROLL_V   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SCROLL_H   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_VOLUME     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BRIGHTNESS = 4'd8;

    // Key tap codes.
    localparam logic [TAP_W-1:0] TAP_NONE   = 2'd0;
    localparam logic [TAP_W-1:0] TAP_FIRST  = 2'd1;
    localparam logic [TAP_W-1:0] TAP_SECOND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RES = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic delta;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

/* hdl/akds_ctrl.sv */
module akds_ctrl
    import akds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                state_next = sts.need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DELTA:
            begin
                cmd.delta = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/akds_dp.sv */
module akds_dp
    import akds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_op,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam logic signed [D_W:0] HALF_S = (D_W + 1)'(1 << (ANGLE_BITS - 1));
    localparam logic signed [D_W:0] FULL_S = (D_W + 1)'(1 << ANGLE_BITS);

    // Configuration registers.
    logic [ACT_W-1:0]  action_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [DZ_W-1:0]   dz_reg;
    logic [DIV_W-1:0]  speed_reg;
    logic              hires_reg;

    // Block state.
    logic [ANGLE_BITS-1:0] ref_reg;
    logic [MODE_W-1:0]     mode_reg;

    // Captured item.
    logic                  op_reg;
    logic [ANGLE_BITS-1:0] ang_reg;
    logic [LOCK_N-1:0]     lock_reg;

    // Delta and divider.
    logic signed [D_W-1:0] delta_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      quo_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [WIDE_W-1:0]     ang_wide;
    logic signed [D_W:0]   diff_raw;
    logic signed [D_W:0]   diff_wrap;
    logic signed [D_W-1:0] delta_next;
    logic signed [D_W-1:0] abs_full;
    logic [MAG_W-1:0]      mag_next;
    logic                  is_scroll;
    logic                  is_key;

    logic [DIV_W-1:0]      div_eff;
    logic [REM_W-1:0]      rem_sh;
    logic                  rem_fits;

    logic signed [CMP_W-1:0] d_ext;
    logic signed [CMP_W-1:0] tc_ext;
    logic                  pos_hit;
    logic                  neg_hit;
    logic                  hr_fire;
    logic [QW-1:0]         q_wide;
    logic signed [SCR_W-1:0] amt_mag;
    logic signed [SCR_W-1:0] amt;
    logic                  fire;
    logic [TAP_W-1:0]      tap_res;
    logic [MODE_W-1:0]     mode_res;
    logic signed [SCR_W-1:0] sv_res;
    logic signed [SCR_W-1:0] sh_res;

    assign ang_wide = WIDE_W'(in_data[ANG_IN_W-1:0]);
    assign is_scroll = (mode_reg == MODE_SCROLL_V) || (mode_reg == MODE_SCROLL_H);
    assign is_key    = mode_reg inside {[MODE_VOLUME:MODE_BRIGHTNESS]};

    // Shortest signed distance on the circle; exactly half a turn keeps its sign.
    always_comb
    begin
        diff_raw = $signed({2'b00, ang_reg}) - $signed({2'b00, ref_reg});
        if (diff_raw > HALF_S)
        begin
            diff_wrap = diff_raw - FULL_S;
        end
        else if (diff_raw < -HALF_S)
        begin
            diff_wrap = diff_raw + FULL_S;
        end
        else
        begin
            diff_wrap = diff_raw;
        end
        delta_next = diff_wrap[D_W-1:0];
        abs_full   = delta_next[D_W-1] ? -delta_next : delta_next;
        mag_next   = abs_full[MAG_W-1:0];
    end

    assign sts.need_div = (op_reg == OP_SAMPLE) && is_scroll && hires_reg &&
                          (CMP_W'(mag_next) > CMP_W'(dz_reg));
    assign sts.div_done = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    // Restoring divider, one quotient bit per step.
    assign div_eff  = (speed_reg == '0) ? DIV_W'(1) : speed_reg;
    assign rem_sh   = {rem_reg[REM_W-2:0], quo_reg[MAG_W-1]};
    assign rem_fits = rem_sh >= {1'b0, div_eff};

    // Result of the item, valid in the emit step.
    always_comb
    begin
        d_ext   = CMP_W'(delta_reg);
        tc_ext  = $signed(CMP_W'(tick_reg));
        pos_hit = d_ext >= tc_ext;
        neg_hit = d_ext <= -tc_ext;
        hr_fire = CMP_W'(mag_reg) > CMP_W'(dz_reg);

        q_wide = QW'(quo_reg);
        if (q_wide > QW'(SCROLL_MAX))
        begin
            q_wide = QW'(SCROLL_MAX);
        end
        amt_mag = $signed(q_wide[SCR_W-1:0]);

        tap_res  = TAP_NONE;
        mode_res = mode_reg;
        sv_res   = '0;
        sh_res   = '0;
        fire     = 1'b0;
        amt      = '0;

        if (op_reg == OP_LOCK)
        begin
            if (lock_reg[0] && (action_reg[7:4] != MODE_NONE))
            begin
                mode_res = action_reg[7:4];
            end
            else if (lock_reg[1] && (action_reg[11:8] != MODE_NONE))
            begin
                mode_res = action_reg[11:8];
            end
            else if (lock_reg[2] && (action_reg[15:12] != MODE_NONE))
            begin
                mode_res = action_reg[15:12];
            end
            else if (lock_reg[3] && (action_reg[19:16] != MODE_NONE))
            begin
                mode_res = action_reg[19:16];
            end
            else if (lock_reg[4] && (action_reg[23:20] != MODE_NONE))
            begin
                mode_res = action_reg[23:20];
            end
            else
            begin
                mode_res = action_reg[3:0];
            end
        end
        else if (is_scroll)
        begin
            if (hires_reg)
            begin
                fire = hr_fire;
                amt  = delta_reg[D_W-1] ? -amt_mag : amt_mag;
            end
            else if (pos_hit)
            begin
                fire = 1'b1;
                amt  = SCR_W'(1);
            end
            else if (neg_hit)
            begin
                fire = 1'b1;
                amt  = -SCR_W'(1);
            end
            if (fire)
            begin
                if (mode_reg == MODE_SCROLL_H)
                begin
                    sh_res = hires_reg ? -amt : amt;
                end
                else
                begin
                    sv_res = amt;
                end
            end
        end
        else if (is_key)
        begin
            if (pos_hit)
            begin
                fire    = 1'b1;
                tap_res = TAP_FIRST;
            end
            else if (neg_hit)
            begin
                fire    = 1'b1;
                tap_res = TAP_SECOND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_W'(1);
            tick_reg   <= TICK_W'(32);
            dz_reg     <= DZ_W'(4);
            speed_reg  <= DIV_W'(4);
            hires_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACTION:   action_reg <= cfg_data[ACT_W-1:0];
                REG_TICK:     tick_reg   <= cfg_data[TICK_W-1:0];
                REG_DEADZONE: dz_reg     <= cfg_data[DZ_W-1:0];
                REG_SPEED:    speed_reg  <= cfg_data[DIV_W-1:0];
                REG_HIGH_RES: hires_reg  <= cfg_data[0];
                default:      action_reg <= action_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= '0;
            mode_reg      <= MODE_NONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.delta)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                mode_reg <= mode_res;
                if ((op_reg == OP_LOCK) || fire)
                begin
                    ref_reg <= ang_reg;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            ang_reg  <= ang_wide[ANGLE_BITS-1:0];
            lock_reg <= in_data[ANG_IN_W +: LOCK_N];
        end
        if (cmd.delta)
        begin
            delta_reg <= delta_next;
            mag_reg   <= mag_next;
            quo_reg   <= mag_next;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_fits)
            begin
                rem_reg <= rem_sh - {1'b0, div_eff};
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= {sh_res, sv_res, mode_res, tap_res};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/angle_knob_detent_scroll.sv */
// Channel   Direction  Beat contents
// s_axis    in         tuser: op; tdata: angle, num, caps, scroll, compose, kana locks
// m_axis    out        tdata: key_tap, active_mode, scroll_vertical, scroll_horizontal
// cfg       in         cfg_index selects a register, cfg_data carries its value
//
// An item passes through the accept, delta and emit steps when no division is needed,
// and also through the twelve-step serial divider when a high-resolution scroll sample
// exceeds the dead zone. One item is worked on at a time. The result register lets the
// next beat be accepted while the previous result still waits on m_axis_tready; a
// stalled output holds the emit step until the register frees. Reset is asynchronous
// and active low; there is no clearing pass and configuration returns to its defaults.
`include "assert_macros.svh"

module angle_knob_detent_scroll
    import akds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input beats. tdata from bit 0 up: angle[11:0], then the num, caps,
    // scroll, compose and kana indicators, zero fill to 24 bits.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0 up: op (0 angle sample, 1 lock-state update).
    input  logic                  s_axis_tuser,

    // Result beats. tdata from bit 0 up: key_tap[1:0], active_mode[3:0],
    // scroll_vertical[12:0], scroll_horizontal[12:0].
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    // Configuration writes; the block always takes them.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // The controller sequences accept, delta, divide and emit steps.
    akds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds configuration, the reference angle, the mode, the divider
    // and the result register.
    akds_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // A new beat is never taken while the previous one is still being worked on.
    `AKDS_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready), "beat accepted while busy")
    // A result is only written into a free result register.
    `AKDS_ASSERT_ALWAYS(a_emit_free, (cmd.emit |-> sts.out_free), "result register overwritten")
    // The divider stops after its last step.
    `AKDS_ASSERT(a_div_stops, (cmd.div_step && sts.div_done |=> !cmd.div_step), "divider overran")
    // A key tap never comes with a scroll amount.
    `AKDS_ASSERT(a_tap_no_scroll, (m_axis_tvalid && (m_axis_tdata[1:0] != TAP_NONE) |-> (m_axis_tdata[31:6] == '0)), "tap with scroll")

endmodule

/* tb/tb_angle_knob_detent_scroll.sv */
`timescale 1ns / 100ps

// Self-checking bench for the detent scroll knob. A driver pushes sensor beats from
// a queue of pending items, a monitor pulls result beats, and a predictor written
// against the block's behavior tracks the reference angle and the active mode.
// Both sides insert random idle cycles, and configuration is rewritten between
// phases only once every awaited result has come back.
module tb_angle_knob_detent_scroll;
    import akds_pkg::*;

    // Mode codes that the package leaves unnamed.
    localparam logic [MODE_W-1:0] MODE_ARROWS_V = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ARROWS_H = 4'd5;
    localparam logic [MODE_W-1:0] MODE_WASD_V   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_WASD_H   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 4'd9;

    // Lock indicator patterns. Bit i of the lock field selects table slot i + 1.
    localparam logic [LOCK_N-1:0] LK_NONE    = 5'b00000;
    localparam logic [LOCK_N-1:0] LK_NUM     = 5'b00001;
    localparam logic [LOCK_N-1:0] LK_CAPS    = 5'b00010;
    localparam logic [LOCK_N-1:0] LK_SCROLL  = 5'b00100;
    localparam logic [LOCK_N-1:0] LK_COMPOSE = 5'b01000;
    localparam logic [LOCK_N-1:0] LK_KANA    = 5'b10000;
    localparam logic [LOCK_N-1:0] LK_ALL     = 5'b11111;

    localparam int ANG_FULL = 1 << ANGLE_BITS;
    localparam int ANG_HALF = ANG_FULL / 2;
    localparam int ANG_MAX  = ANG_FULL - 1;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 11;
    localparam int MAX_WAIT        = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int DRAIN_EVERY     = 211;

    // Input beat: tdata from bit 0 up holds angle, then the five lock flags.
    typedef struct packed {
        logic [IN_DATA_W-ANG_IN_W-LOCK_N-1:0] pad;
        logic [LOCK_N-1:0]                    locks;
        logic [ANG_IN_W-1:0]                  angle;
    } knob_beat_t;

    // Result beat: tdata from bit 0 up holds key_tap, active_mode, vertical, horizontal.
    typedef struct packed {
        logic [SCR_W-1:0]  scroll_h;
        logic [SCR_W-1:0]  scroll_v;
        logic [MODE_W-1:0] mode;
        logic [TAP_W-1:0]  tap;
    } knob_result_t;

    // One pending item. When drain is set, the driver holds this item back until
    // every result already awaited has arrived.
    typedef struct {
        logic              op;
        logic [ANG_IN_W-1:0] angle;
        logic [LOCK_N-1:0] locks;
        bit                drain;
    } knob_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Bench copy of the configuration, starting from the reset defaults.
    logic [ACT_W-1:0]      cfg_action   = 24'd1;
    logic [TICK_W-1:0]     cfg_tick     = 12'd32;
    logic [DZ_W-1:0]       cfg_dz       = 11'd4;
    logic [DIV_W-1:0]      cfg_speed    = 12'd4;
    logic                  cfg_high_res = 1'b1;

    // Bench copy of the block state: the captured reference angle and the mode in force.
    logic [ANGLE_BITS-1:0] knob_ref_angle = '0;
    logic [MODE_W-1:0]     knob_mode = MODE_NONE;

    knob_item_t            knob_items[$];
    knob_result_t          awaited_reports[$];

    int                    fail_count = 0;
    int                    cycle_count = 0;
    int                    gap_left = 0;
    int                    stall_left = 0;
    bit                    no_idle = 1'b0;

    angle_knob_detent_scroll uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Works out the result of one accepted beat and advances the bench state.
    // A lock update picks the first lit indicator whose table slot is in use, falling
    // back to the default slot, and recaptures the angle. A sample measures the
    // shortest signed distance around the circle and acts according to the mode.
    function automatic knob_result_t detent_response(input logic op, input knob_beat_t beat);
        knob_result_t          r;
        logic [ANGLE_BITS-1:0] ang;
        logic [MODE_W-1:0]     code;
        int                    d;
        int                    mag;
        int                    amt;
        int                    tc;
        int                    divisor;
        bit                    fire;
        bit                    found;
        r = '0;
        amt = 0;
        fire = 1'b0;
        found = 1'b0;
        ang = beat.angle[ANGLE_BITS-1:0];
        if (op == OP_LOCK) begin
            for (int i = 0; i < LOCK_N; i++) begin
                code = cfg_action[(i + 1) * MODE_W +: MODE_W];
                if (!found && beat.locks[i] && code != MODE_NONE) begin
                    knob_mode = code;
                    found = 1'b1;
                end
            end
            if (!found)
                knob_mode = cfg_action[MODE_W-1:0];
            knob_ref_angle = ang;
        end else begin
            d = int'(ang) - int'(knob_ref_angle);
            if (d > ANG_HALF)
                d -= ANG_FULL;
            else if (d < -ANG_HALF)
                d += ANG_FULL;
            tc = int'(cfg_tick);
            if (knob_mode == MODE_SCROLL_V || knob_mode == MODE_SCROLL_H) begin
                if (cfg_high_res) begin
                    // The dead zone must be exceeded; a zero divisor behaves as one.
                    if (d > int'(cfg_dz) || d < -int'(cfg_dz)) begin
                        divisor = (cfg_speed == '0) ? 1 : int'(cfg_speed);
                        mag = ((d < 0) ? -d : d) / divisor;
                        amt = (d < 0) ? -mag : mag;
                        fire = 1'b1;
                    end
                end else if (d >= tc) begin
                    amt = 1;
                    fire = 1'b1;
                end else if (d <= -tc) begin
                    amt = -1;
                    fire = 1'b1;
                end
                if (fire) begin
                    knob_ref_angle = ang;
                    // Horizontal scrolling runs the other way on a high-resolution host.
                    if (knob_mode == MODE_SCROLL_H && cfg_high_res)
                        amt = -amt;
                    if (amt > SCROLL_MAX)
                        amt = SCROLL_MAX;
                    else if (amt < -SCROLL_MAX)
                        amt = -SCROLL_MAX;
                    if (knob_mode == MODE_SCROLL_H)
                        r.scroll_h = amt[SCR_W-1:0];
                    else
                        r.scroll_v = amt[SCR_W-1:0];
                end
            end else if (knob_mode > MODE_SCROLL_H && knob_mode <= MODE_BRIGHTNESS) begin
                // Key modes tap once the threshold is reached in either direction.
                if (d >= tc) begin
                    r.tap = TAP_FIRST;
                    knob_ref_angle = ang;
                end else if (d <= -tc) begin
                    r.tap = TAP_SECOND;
                    knob_ref_angle = ang;
                end
            end
        end
        r.mode = knob_mode;
        return r;
    endfunction

    // Idle cycles ahead of one beat. At least a quarter of the draws are zero so that
    // back to back traffic stays common, and whole phases can run with no idling at all.
    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic check_field(input string field, input logic signed [SCR_W-1:0] want,
                               input logic signed [SCR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Driver. When a beat is taken, its result is predicted right away from the bus
    // contents. The next item goes out on the same edge if its drawn gap is zero, so
    // tvalid stays high across back-to-back beats without being toggled.
    always @(posedge clk) begin : beat_driver
        knob_item_t it;
        knob_beat_t b;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_reports.push_back(detent_response(s_axis_tuser,
                                                          knob_beat_t'(s_axis_tdata)));
            if (s_axis_tvalid && !s_axis_tready) begin
                // The current beat is still on offer; hold it.
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (knob_items.size() != 0 &&
                         !(knob_items[0].drain && awaited_reports.size() != 0)) begin
                it = knob_items.pop_front();
                b = '0;
                b.angle = it.angle;
                b.locks = it.locks;
                s_axis_tdata <= b;
                s_axis_tuser <= it.op;
                s_axis_tvalid <= 1'b1;
                gap_left <= draw_wait();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor. Every result beat is matched against the oldest awaited result, field
    // by field, and then tready drops for a freshly drawn number of cycles.
    always @(posedge clk) begin : result_monitor
        knob_result_t got;
        knob_result_t want;
        int w;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = knob_result_t'(m_axis_tdata);
            if (awaited_reports.size() == 0) begin
                $display("%0t: result beat %h arrived with nothing awaited", $time,
                         m_axis_tdata);
                fail_count++;
            end else begin
                want = awaited_reports.pop_front();
                check_field("key_tap", want.tap, got.tap);
                check_field("active_mode", want.mode, got.mode);
                check_field("scroll_vertical", $signed(want.scroll_v), $signed(got.scroll_v));
                check_field("scroll_horizontal", $signed(want.scroll_h),
                            $signed(got.scroll_h));
            end
            w = draw_wait();
            stall_left <= w;
            m_axis_tready <= (w == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_angle_knob_detent_scroll: done, errors");
            $finish;
        end
    end

    task automatic queue_item(input logic op, input int ang, input logic [LOCK_N-1:0] locks,
                              input bit drain = 1'b0);
        knob_item_t it;
        it.op = op;
        it.angle = ang[ANG_IN_W-1:0];
        it.locks = locks;
        it.drain = drain;
        knob_items.push_back(it);
    endtask

    // Returns once nothing is queued, on offer or awaited. The condition must be seen
    // again after it first holds, since the driver may launch a beat on the edge where
    // the queue runs empty.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < 2) begin
            @(posedge clk);
            if (knob_items.size() == 0 && !s_axis_tvalid && awaited_reports.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // Offers one register write and waits for it to be taken. cfg_valid stays high so
    // that consecutive writes go out back to back; the caller lowers it afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_ACTION:   cfg_action = val[ACT_W-1:0];
            REG_TICK:     cfg_tick = val[TICK_W-1:0];
            REG_DEADZONE: cfg_dz = val[DZ_W-1:0];
            REG_SPEED:    cfg_speed = val[DIV_W-1:0];
            REG_HIGH_RES: cfg_high_res = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [ACT_W-1:0] action, input int tick,
                                  input int dz, input int speed, input bit high_res);
        write_reg(REG_ACTION, CFG_DATA_W'(action));
        write_reg(REG_TICK, CFG_DATA_W'(tick));
        write_reg(REG_DEADZONE, CFG_DATA_W'(dz));
        write_reg(REG_SPEED, CFG_DATA_W'(speed));
        write_reg(REG_HIGH_RES, CFG_DATA_W'(high_res));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ACT_W-1:0] pack_modes(
        input logic [MODE_W-1:0] dflt, input logic [MODE_W-1:0] num,
        input logic [MODE_W-1:0] caps, input logic [MODE_W-1:0] scrl,
        input logic [MODE_W-1:0] comp, input logic [MODE_W-1:0] kana);
        return {kana, comp, scrl, caps, num, dflt};
    endfunction

    initial begin : stimulus
        logic [ACT_W-1:0] action;
        int tick;
        int dz;
        int speed;
        bit high_res;
        int reach;
        int knob_pos;
        int roll;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings. The mode starts out as none, so the first sample does nothing.
        // The lock update selects the default slot (vertical scroll), then samples
        // cover the dead zone, both half-circle extremes and the wrap at zero.
        queue_item(OP_SAMPLE, 100, LK_ALL);
        queue_item(OP_LOCK, 0, LK_NONE);
        queue_item(OP_SAMPLE, ANG_MAX, LK_NONE);
        queue_item(OP_SAMPLE, ANG_HALF, LK_NONE);
        queue_item(OP_SAMPLE, 0, LK_NONE);
        queue_item(OP_SAMPLE, 5, LK_NONE);
        queue_item(OP_SAMPLE, 1, LK_NONE);
        wait_idle();

        // Every slot in use, a zero dead zone and a zero divisor. Horizontal scrolling
        // reaches the largest amounts in both directions; the lock updates walk the
        // priority order down to the unknown code in the kana slot.
        apply_settings(pack_modes(MODE_SCROLL_H, MODE_VOLUME, MODE_ARROWS_V, MODE_ARROWS_H,
                                  MODE_BRIGHTNESS, MODE_UNKNOWN), 32, 0, 0, 1'b1);
        queue_item(OP_LOCK, ANG_MAX, LK_NONE);
        queue_item(OP_SAMPLE, ANG_MAX, LK_NONE);
        queue_item(OP_SAMPLE, 0, LK_NONE);
        queue_item(OP_SAMPLE, ANG_HALF, LK_NONE);
        queue_item(OP_SAMPLE, 0, LK_NONE);
        queue_item(OP_LOCK, 100, LK_ALL);
        queue_item(OP_SAMPLE, 132, LK_NONE);
        queue_item(OP_SAMPLE, 100, LK_NONE);
        queue_item(OP_SAMPLE, 131, LK_NONE);
        queue_item(OP_LOCK, 0, LK_CAPS | LK_SCROLL | LK_KANA);
        queue_item(OP_LOCK, 0, LK_SCROLL | LK_COMPOSE);
        queue_item(OP_LOCK, 0, LK_COMPOSE | LK_KANA);
        queue_item(OP_SAMPLE, ANG_FULL - 32, LK_NONE);
        queue_item(OP_LOCK, 0, LK_KANA);
        queue_item(OP_SAMPLE, ANG_HALF, LK_NONE);
        wait_idle();

        // Step scrolling with a zero tick count: any delta of zero or more counts as
        // reaching the positive threshold, and a negative one the negative threshold.
        apply_settings(pack_modes(MODE_SCROLL_V, MODE_WASD_V, MODE_WASD_H, MODE_NONE,
                                  MODE_NONE, MODE_NONE), 0, 2047, 4095, 1'b0);
        queue_item(OP_LOCK, 7, LK_NONE);
        queue_item(OP_SAMPLE, 7, LK_NONE);
        queue_item(OP_SAMPLE, 6, LK_NONE);
        wait_idle();

        // Random phases. The first three pin the register extremes; the rest draw them.
        // Most samples follow a knob that turns a bounded step at a time, so the
        // thresholds are crossed often; lock updates and jumps anywhere are mixed in.
        knob_pos = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            action = '0;
            for (int s = 0; s < 6; s++)
                action[s * MODE_W +: MODE_W] = ($urandom_range(0, 4) == 0) ?
                    MODE_W'($urandom_range(0, 15)) : MODE_W'($urandom_range(1, 8));
            case (p)
                0: begin tick = 1; dz = 0; speed = 1; high_res = 1'b1; end
                1: begin tick = 2048; dz = 2047; speed = 2048; high_res = 1'b1; end
                2: begin tick = 4095; dz = 0; speed = 4095; high_res = 1'b0; end
                default: begin
                    case ($urandom_range(0, 5))
                        0: tick = 0;
                        1: tick = 2048;
                        default: tick = $urandom_range(1, 64);
                    endcase
                    dz = ($urandom_range(0, 4) == 0) ? 2047 : $urandom_range(0, 32);
                    speed = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) :
                                                         $urandom_range(0, 16);
                    high_res = $urandom_range(0, 1);
                end
            endcase
            apply_settings(action, tick, dz, speed, high_res);
            no_idle = (p % 4 == 3);
            reach = (tick < 16) ? 8 : ((tick > 1024) ? 1024 : tick / 2);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    queue_item(OP_LOCK, knob_pos,
                               ($urandom_range(0, 3) == 0) ? LK_NONE :
                                                             LOCK_N'($urandom_range(0, 31)),
                               ((p * ITEMS_PER_PHASE + k) % DRAIN_EVERY) == 5);
                end else if (roll < 16) begin
                    knob_pos = $urandom_range(0, ANG_MAX);
                    queue_item(OP_SAMPLE, knob_pos, LOCK_N'($urandom_range(0, 31)),
                               ((p * ITEMS_PER_PHASE + k) % DRAIN_EVERY) == 5);
                end else begin
                    knob_pos = (knob_pos + $urandom_range(0, 2 * reach) - reach) & ANG_MAX;
                    queue_item(OP_SAMPLE, knob_pos, LOCK_N'($urandom_range(0, 31)),
                               ((p * ITEMS_PER_PHASE + k) % DRAIN_EVERY) == 5);
                end
            end
            wait_idle();
        end

        // Give any stray result beat time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && awaited_reports.size() == 0)
            $display("tb_angle_knob_detent_scroll: done, clean");
        else
            $display("tb_angle_knob_detent_scroll: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/akds_pkg.sv
hdl/akds_ctrl.sv
hdl/akds_dp.sv
hdl/angle_knob_detent_scroll.sv
tb/tb_angle_knob_detent_scroll.sv
